// ===== sv/xrd_pkg.sv =====
// Shared types, codes and constants of the XML reference decoder.
`default_nettype none
package xrd_pkg;

	// Longest reference body (characters after '&') before ';' must appear
	localparam int unsigned MAX_REF_CHARS = 11;

	localparam int unsigned QUEUE_DEPTH = 2;
	localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// Register index of the configuration port
	localparam logic REG_ATTR_MODE = 1'b0;

	localparam logic [20:0] CP_MAX     = 21'h10FFFF;
	localparam logic [20:0] CP_SUR_LO  = 21'h00D800;
	localparam logic [20:0] CP_SUR_HI  = 21'h00DFFF;

	localparam logic [7:0] CH_AMP   = 8'h26;
	localparam logic [7:0] CH_SEMI  = 8'h3B;
	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_X     = 8'h78;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_SP    = 8'h20;
	localparam logic [7:0] CH_LT    = 8'h3C;
	localparam logic [7:0] CH_GT    = 8'h3E;
	localparam logic [7:0] CH_QUOT  = 8'h22;
	localparam logic [7:0] CH_APOS  = 8'h27;

	localparam logic [31:0] NAME_LT   = 32'h00006C74;
	localparam logic [31:0] NAME_GT   = 32'h00006774;
	localparam logic [31:0] NAME_AMP  = 32'h00616D70;
	localparam logic [31:0] NAME_QUOT = 32'h71756F74;
	localparam logic [31:0] NAME_APOS = 32'h61706F73;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_REF,
		PH_DROP
	} phase_t;

	typedef enum logic [1:0] {
		KIND_NAMED,
		KIND_HASH,
		KIND_DEC,
		KIND_HEX
	} kind_t;

	typedef enum logic [2:0] {
		ERR_NONE,
		ERR_AMP,
		ERR_EMPTY,
		ERR_DIGIT,
		ERR_RANGE,
		ERR_VALUE,
		ERR_ENTITY
	} err_t;

	// All results caused by one input item
	typedef struct packed {
		logic [1:0]      last_idx;
		logic [3:0][7:0] bytes;
		logic            has_byte;
		err_t            err;
		logic            run_end;
	} xrd_entry_t;

endpackage
`default_nettype wire

// ===== sv/xml_reference_decoder.sv =====
// Top level of the XML character and entity reference decoder.
// Feed one byte of a text run or attribute value per item, with end_of_run on
// the last byte; each item yields zero to four result items. The front end
// takes a new byte every cycle as long as its two-entry result queue has room,
// and updates the reference state (code point, name characters, kind, length)
// in that same cycle, so a run of ordinary bytes streams at one item per
// cycle. While out_ready is high the output side emits one result item per
// cycle; a character reference of N UTF-8 bytes holds the output until
// all N are out; the input stalls on a full queue. Errors arrive as a result
// with has_byte low and a nonzero error_code; the rest of the run is then
// dropped until end_of_run, which always closes with run_end on the final
// result. attribute_mode sits at address 0 of the APB port: 0 folds CR and
// CR LF to LF, 1 turns space, TAB, LF and CR into a space.
`default_nettype none
module xml_reference_decoder #(
	parameter int unsigned MAX_REF_LEN = xrd_pkg::MAX_REF_CHARS
) (
	input  wire         clk,
	input  wire         arst_n,
	// input bytes
	input  wire         in_valid,
	output logic        in_ready,
	input  wire  [7:0]  data_byte,
	input  wire         end_of_run,
	// decoded results
	output logic        out_valid,
	input  wire         out_ready,
	output logic [7:0]  out_byte,
	output logic        has_byte,
	output logic [2:0]  error_code,
	output logic        item_last,
	output logic        run_end,
	// configuration
	input  wire         psel,
	input  wire         penable,
	input  wire         pwrite,
	input  wire  [2:0]  paddr,
	input  wire  [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import xrd_pkg::*;

	logic        attr_mode_q;
	logic        q_ready, q_push, q_pop, head_valid;
	xrd_entry_t  q_entry, head_entry;

	// Register file: one mode bit; writes complete in the access phase
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_ATTR_MODE) ? {31'd0, attr_mode_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attr_mode_q <= 1'b0;
		end else if (psel && penable && pwrite && pready && paddr[2] == REG_ATTR_MODE) begin
			attr_mode_q <= pwdata[0];
		end
	end

	// Front: classify the byte and advance reference state
	xrd_front #(
		.MAX_REF_LEN (MAX_REF_LEN)
	) u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.data_byte      (data_byte),
		.end_of_run     (end_of_run),
		.attribute_mode (attr_mode_q),
		.q_ready        (q_ready),
		.q_push         (q_push),
		.q_entry        (q_entry)
	);

	// Queue: decouple the byte intake from the result stream
	xrd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_entry (q_entry),
		.push_ready (q_ready),
		.pop        (q_pop),
		.head_valid (head_valid),
		.head_entry (head_entry)
	);

	// Back: serialize each entry into result items
	xrd_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_entry (head_entry),
		.pop        (q_pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_byte   (out_byte),
		.has_byte   (has_byte),
		.error_code (error_code),
		.item_last  (item_last),
		.run_end    (run_end)
	);

endmodule
`default_nettype wire

// ===== sv/xrd_front.sv =====
// Front end: accepts input bytes, tracks reference state and builds result entries.
`default_nettype none
module xrd_front #(
	parameter int unsigned MAX_REF_LEN = xrd_pkg::MAX_REF_CHARS
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 in_valid,
	output logic                in_ready,
	input  wire  [7:0]          data_byte,
	input  wire                 end_of_run,
	input  wire                 attribute_mode,
	input  wire                 q_ready,
	output logic                q_push,
	output xrd_pkg::xrd_entry_t q_entry
);
	import xrd_pkg::*;

	phase_t      phase_q, phase_n;
	kind_t       kind_q, kind_n;
	logic [20:0] cp_q, cp_n;
	logic [3:0]  len_q, len_n;
	logic [31:0] name_q, name_n;
	err_t        fce_q, fce_n;
	logic        cr_q, cr_n;

	err_t        fin_err;
	xrd_entry_t  fin_ent;
	logic        dig_en, dig_hex, dig_ok;
	logic [3:0]  dig_val;
	logic [24:0] acc;
	logic        cr_seen, is_ws, has_res;
	err_t        step_err;
	xrd_entry_t  ent;

	assign in_ready = q_ready;

	// Closing ';': resolve the reference into bytes or an error code
	always_comb begin
		fin_err = ERR_NONE;
		fin_ent = '0;
		fin_ent.has_byte = 1'b1;
		if (fce_q != ERR_NONE) begin
			fin_err = fce_q;
		end else if (kind_q == KIND_NAMED) begin
			if (len_q == 4'd2 && name_q == NAME_LT) begin
				fin_ent.bytes[0] = CH_LT;
			end else if (len_q == 4'd2 && name_q == NAME_GT) begin
				fin_ent.bytes[0] = CH_GT;
			end else if (len_q == 4'd3 && name_q == NAME_AMP) begin
				fin_ent.bytes[0] = CH_AMP;
			end else if (len_q == 4'd4 && name_q == NAME_QUOT) begin
				fin_ent.bytes[0] = CH_QUOT;
			end else if (len_q == 4'd4 && name_q == NAME_APOS) begin
				fin_ent.bytes[0] = CH_APOS;
			end else begin
				fin_err = ERR_ENTITY;
			end
		end else if (kind_q == KIND_HASH || (kind_q == KIND_HEX && len_q <= 4'd2)) begin
			fin_err = ERR_EMPTY;
		end else if (cp_q == 21'd0 || (cp_q >= CP_SUR_LO && cp_q <= CP_SUR_HI)) begin
			fin_err = ERR_VALUE;
		end else if (cp_q < 21'h80) begin
			fin_ent.bytes[0] = cp_q[7:0];
		end else if (cp_q < 21'h800) begin
			fin_ent.last_idx = 2'd1;
			fin_ent.bytes[0] = {3'b110, cp_q[10:6]};
			fin_ent.bytes[1] = {2'b10, cp_q[5:0]};
		end else if (cp_q < 21'h10000) begin
			fin_ent.last_idx = 2'd2;
			fin_ent.bytes[0] = {4'b1110, cp_q[15:12]};
			fin_ent.bytes[1] = {2'b10, cp_q[11:6]};
			fin_ent.bytes[2] = {2'b10, cp_q[5:0]};
		end else begin
			fin_ent.last_idx = 2'd3;
			fin_ent.bytes[0] = {5'b11110, cp_q[20:18]};
			fin_ent.bytes[1] = {2'b10, cp_q[17:12]};
			fin_ent.bytes[2] = {2'b10, cp_q[11:6]};
			fin_ent.bytes[3] = {2'b10, cp_q[5:0]};
		end
	end

	// Digit decode for the numeric forms
	always_comb begin
		dig_ok  = 1'b0;
		dig_val = 4'd0;
		if (data_byte >= 8'h30 && data_byte <= 8'h39) begin
			dig_ok  = 1'b1;
			dig_val = data_byte[3:0];
		end else if (dig_hex && data_byte >= 8'h61 && data_byte <= 8'h66) begin
			dig_ok  = 1'b1;
			dig_val = data_byte[3:0] + 4'd9;
		end else if (dig_hex && data_byte >= 8'h41 && data_byte <= 8'h46) begin
			dig_ok  = 1'b1;
			dig_val = data_byte[3:0] + 4'd9;
		end
		if (dig_hex) begin
			acc = {cp_q, 4'd0} + {21'd0, dig_val};
		end else begin
			acc = {1'b0, cp_q, 3'd0} + {3'd0, cp_q, 1'b0} + {21'd0, dig_val};
		end
	end

	always_comb begin
		dig_en = 1'b0;
		dig_hex = (kind_q == KIND_HEX);
		case (kind_q)
			KIND_HASH: dig_en = (data_byte != CH_X);
			KIND_DEC:  dig_en = 1'b1;
			KIND_HEX:  dig_en = 1'b1;
			default:   dig_en = 1'b0;
		endcase
	end

	always_comb begin
		phase_n  = phase_q;
		kind_n   = kind_q;
		cp_n     = cp_q;
		len_n    = len_q;
		name_n   = name_q;
		fce_n    = fce_q;
		cr_n     = cr_q;
		ent      = '0;
		has_res  = 1'b0;
		step_err = ERR_NONE;
		cr_seen  = cr_q && !attribute_mode;
		is_ws    = data_byte == CH_SP || data_byte == CH_TAB ||
			data_byte == CH_LF || data_byte == CH_CR;

		case (phase_q)
			PH_IDLE: begin
				cr_n = 1'b0;
				ent.has_byte = 1'b1;
				if (data_byte == CH_AMP) begin
					phase_n = PH_REF;
					kind_n  = KIND_NAMED;
					cp_n    = '0;
					len_n   = '0;
					name_n  = '0;
					fce_n   = ERR_NONE;
				end else if (attribute_mode) begin
					has_res = 1'b1;
					ent.bytes[0] = is_ws ? CH_SP : data_byte;
				end else if (data_byte == CH_CR) begin
					has_res = 1'b1;
					ent.bytes[0] = CH_LF;
					cr_n = 1'b1;
				end else if (!(data_byte == CH_LF && cr_seen)) begin
					has_res = 1'b1;
					ent.bytes[0] = data_byte;
				end
			end
			PH_REF: begin
				if (data_byte == CH_SEMI) begin
					step_err = fin_err;
					if (fin_err == ERR_NONE) begin
						phase_n = PH_IDLE;
						has_res = 1'b1;
						ent     = fin_ent;
					end
				end else if (len_q >= 4'(MAX_REF_LEN)) begin
					step_err = ERR_AMP;
				end else begin
					len_n = len_q + 4'd1;
					case (kind_q)
						KIND_NAMED: begin
							if (len_q == 4'd0 && data_byte == CH_HASH) begin
								kind_n = KIND_HASH;
							end else begin
								name_n = {name_q[23:0], data_byte};
							end
						end
						KIND_HASH: kind_n = (data_byte == CH_X) ? KIND_HEX : KIND_DEC;
						default:   kind_n = kind_q;
					endcase
					if (dig_en && fce_q == ERR_NONE) begin
						if (!dig_ok) begin
							fce_n = ERR_DIGIT;
						end else if (acc > {4'd0, CP_MAX}) begin
							fce_n = ERR_RANGE;
						end else begin
							cp_n = acc[20:0];
						end
					end
				end
				if (step_err != ERR_NONE) begin
					has_res = 1'b1;
					ent     = '0;
					ent.err = step_err;
					phase_n = PH_DROP;
				end
			end
			default: phase_n = PH_DROP;
		endcase

		// End of run: flag an open reference, else add a bare end marker if silent
		if (end_of_run) begin
			if (phase_n == PH_REF) begin
				ent     = '0;
				ent.err = ERR_AMP;
			end else if (!has_res) begin
				ent = '0;
			end
			has_res     = 1'b1;
			ent.run_end = 1'b1;
			phase_n     = PH_IDLE;
			cr_n        = 1'b0;
			kind_n      = KIND_NAMED;
			cp_n        = '0;
			len_n       = '0;
			name_n      = '0;
			fce_n       = ERR_NONE;
		end
	end

	assign q_push  = in_valid && in_ready && has_res;
	assign q_entry = ent;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			kind_q  <= KIND_NAMED;
			cp_q    <= '0;
			len_q   <= '0;
			name_q  <= '0;
			fce_q   <= ERR_NONE;
			cr_q    <= 1'b0;
		end else if (in_valid && in_ready) begin
			phase_q <= phase_n;
			kind_q  <= kind_n;
			cp_q    <= cp_n;
			len_q   <= len_n;
			name_q  <= name_n;
			fce_q   <= fce_n;
			cr_q    <= cr_n;
		end
	end

endmodule
`default_nettype wire

// ===== sv/xrd_queue.sv =====
// Short entry queue between the front end and the output serializer.
`default_nettype none
module xrd_queue (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 push,
	input  xrd_pkg::xrd_entry_t push_entry,
	output logic                push_ready,
	input  wire                 pop,
	output logic                head_valid,
	output xrd_pkg::xrd_entry_t head_entry
);
	import xrd_pkg::*;

	xrd_entry_t          store_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0]   count_q;

	function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
		if (p == QPTR_W'(QUEUE_DEPTH - 1)) begin
			return '0;
		end
		return p + QPTR_W'(1);
	endfunction

	assign push_ready = (count_q != QCNT_W'(QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head_entry = store_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			store_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

endmodule
`default_nettype wire

// ===== sv/xrd_back.sv =====
// Back end: walks the head entry and hands out one result item per cycle while out_ready is high.
`default_nettype none
module xrd_back (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 head_valid,
	input  xrd_pkg::xrd_entry_t head_entry,
	output logic                pop,
	output logic                out_valid,
	input  wire                 out_ready,
	output logic [7:0]          out_byte,
	output logic                has_byte,
	output logic [2:0]          error_code,
	output logic                item_last,
	output logic                run_end
);
	import xrd_pkg::*;

	logic [1:0] idx_q;

	assign out_valid  = head_valid;
	assign out_byte   = head_entry.bytes[idx_q];
	assign has_byte   = head_entry.has_byte;
	assign error_code = head_entry.err;
	assign item_last  = (idx_q == head_entry.last_idx);
	assign run_end    = item_last && head_entry.run_end;
	assign pop        = out_valid && out_ready && item_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (out_valid && out_ready) begin
			idx_q <= item_last ? 2'd0 : idx_q + 2'd1;
		end
	end

endmodule
`default_nettype wire
